>>> design/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants, types and register codes for the wildcard byte pattern
// scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // sizes fixed by the pattern registers and result fields
    localparam int BYTE_W       = 8;
    localparam int MAX_PATTERN  = 16;
    localparam int MAX_CAPTURE  = 4;
    localparam int OUT_CAPS     = 4;
    localparam int OFFSET_BITS  = 32;
    localparam int OFFSET_OUT_W = 32;
    localparam int LEN_W        = 5;
    localparam int CAP_CNT_W    = 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;

    // derived sizes
    localparam int WIN_IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int WIN_BITS  = MAX_PATTERN * BYTE_W;
    localparam int CAP_SLOTS = (MAX_CAPTURE < OUT_CAPS) ? MAX_CAPTURE : OUT_CAPS;
    localparam int CAPS_W    = OUT_CAPS * BYTE_W;

    // register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_EXACT_MASK     = 3'd2,
        REG_CAPTURE_MASK   = 3'd3,
        REG_PATTERN_LENGTH = 3'd4
    } cfg_reg_t;

    typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_win_t;
    typedef logic [WIN_IDX_W-1:0]               win_idx_t;
    typedef logic [OFFSET_BITS-1:0]             count_t;

    // pattern settings remapped onto window taps (tap 0 is the newest byte)
    typedef struct packed {
        logic [LEN_W-1:0]                   len;
        logic [MAX_PATTERN-1:0]             exact_win;
        byte_win_t                          expect_win;
        logic [CAP_SLOTS-1:0][WIN_IDX_W-1:0] cap_tap;
        logic [CAP_CNT_W-1:0]               cap_num;
    } cfg_derived_t;

    // status of the beat held in the window stage
    typedef struct packed {
        logic valid;
        logic active;
        logic last;
    } scan_stat_t;

    // compare outcome for the current window
    typedef struct packed {
        logic                   hit;
        logic [OFFSET_OUT_W-1:0] offset;
        logic [CAPS_W-1:0]      caps;
        logic [CAP_CNT_W-1:0]   cap_num;
    } match_res_t;

endpackage

>>> design/wbps_ifs.sv
// ----------------------------------------------------------------------------
// wbps_ifs
// Valid/ready channels of the scanner: byte stream in, scan result out.
// ----------------------------------------------------------------------------
interface wbps_scan_if import wbps_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              region_end;

    modport source (output valid, output data_byte, output region_end, input ready);
    modport sink   (input valid, input data_byte, input region_end, output ready);
endinterface

interface wbps_result_if import wbps_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [OFFSET_OUT_W-1:0] match_offset;
    logic [CAPS_W-1:0]       captured_bytes;
    logic [CAP_CNT_W-1:0]    capture_count;

    modport source (output valid, output found, output match_offset,
                    output captured_bytes, output capture_count, input ready);
    modport sink   (input valid, input found, input match_offset,
                    input captured_bytes, input capture_count, output ready);
endinterface

>>> design/wbps_cfg.sv
// ----------------------------------------------------------------------------
// wbps_cfg
// Pattern registers and their remapping onto window taps, which is itself
// held in a register.
// ----------------------------------------------------------------------------
module wbps_cfg import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_derived_t           derived
);

    logic [CFG_DATA_W-1:0]  pattern_low_reg;
    logic [CFG_DATA_W-1:0]  pattern_high_reg;
    logic [MAX_PATTERN-1:0] exact_mask_reg;
    logic [MAX_PATTERN-1:0] capture_mask_reg;
    logic [LEN_W-1:0]       pattern_length_reg;

    cfg_derived_t derived_reg;
    cfg_derived_t derived_next;

    logic [LEN_W-1:0]                len_eff;
    logic [2*CFG_DATA_W-1:0]         pat_all;
    logic [MAX_PATTERN-1:0]          in_len;
    logic [MAX_PATTERN-1:0]          cap_pos;
    logic [MAX_PATTERN-1:0][LEN_W-1:0] rank;
    logic [LEN_W-1:0]                cap_total;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            exact_mask_reg     <= '0;
            capture_mask_reg   <= '0;
            pattern_length_reg <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                REG_EXACT_MASK:     exact_mask_reg     <= cfg_data[MAX_PATTERN-1:0];
                REG_CAPTURE_MASK:   capture_mask_reg   <= cfg_data[MAX_PATTERN-1:0];
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamp length, map pattern positions onto window taps, rank captures
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] tap_full;
        logic [MAX_PATTERN-1:0] below;

        if (pattern_length_reg == '0)
            len_eff = LEN_W'(1);
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN))
            len_eff = LEN_W'(MAX_PATTERN);
        else
            len_eff = pattern_length_reg;

        pat_all = {pattern_high_reg, pattern_low_reg};

        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            in_len[j]  = (LEN_W'(j) < len_eff);
            cap_pos[j] = capture_mask_reg[j] & ~exact_mask_reg[j] & in_len[j];
        end

        derived_next.len = len_eff;

        // tap i holds pattern position len-1-i
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos = len_eff - LEN_W'(1) - LEN_W'(i);
            derived_next.exact_win[i]  = in_len[i] & exact_mask_reg[pos[WIN_IDX_W-1:0]];
            derived_next.expect_win[i] = pat_all[BYTE_W*pos[WIN_IDX_W-1:0] +: BYTE_W];
        end

        // rank of each capture position among earlier ones
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            below   = (MAX_PATTERN'(1) << j) - MAX_PATTERN'(1);
            rank[j] = LEN_W'($countones(cap_pos & below));
        end

        for (int k = 0; k < CAP_SLOTS; k++)
        begin
            derived_next.cap_tap[k] = '0;
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                tap_full = len_eff - LEN_W'(1) - LEN_W'(j);
                if (cap_pos[j] && rank[j] == LEN_W'(k))
                    derived_next.cap_tap[k] = derived_next.cap_tap[k]
                                              | tap_full[WIN_IDX_W-1:0];
            end
        end

        cap_total = LEN_W'($countones(cap_pos));
        if (cap_total > LEN_W'(CAP_SLOTS))
            derived_next.cap_num = CAP_CNT_W'(CAP_SLOTS);
        else
            derived_next.cap_num = CAP_CNT_W'(cap_total);
    end

    // derived settings, registered from the pattern registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derived_reg <= '{len: LEN_W'(1), default: '0};
        end
        else
        begin
            derived_reg <= derived_next;
        end
    end

    assign derived = derived_reg;

endmodule

>>> design/wbps_window.sv
// ----------------------------------------------------------------------------
// wbps_window
// Byte window, byte count and match flag of the current region; holds the
// latest beat for the compare stage.
// ----------------------------------------------------------------------------
module wbps_window import wbps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              region_end,
    input  logic              advance,
    input  logic              hit,
    output byte_win_t         win,
    output count_t            count,
    output scan_stat_t        stat
);

    byte_win_t  win_reg;
    byte_win_t  win_next;
    count_t     count_reg;
    count_t     count_next;
    logic       reported_reg;
    logic       reported_next;
    scan_stat_t stat_reg;
    scan_stat_t stat_next;

    logic      clear;
    byte_win_t win_base;
    count_t    count_base;
    logic      take;

    // state seen by the incoming beat: region cleared or match just found
    always_comb
    begin
        clear         = stat_reg.valid & stat_reg.last;
        win_base      = clear ? '0 : win_reg;
        count_base    = clear ? '0 : count_reg;
        reported_next = clear ? 1'b0
                              : (reported_reg | (stat_reg.valid & stat_reg.active & hit));
        take          = accept & ~reported_next;

        win_next   = take ? byte_win_t'(WIN_BITS'({win_base, data_byte})) : win_base;
        count_next = count_base;
        if (take && count_base != '1)
            count_next = count_base + OFFSET_BITS'(1);

        stat_next.valid  = accept;
        stat_next.active = take;
        stat_next.last   = region_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg      <= '0;
            count_reg    <= '0;
            reported_reg <= 1'b0;
            stat_reg     <= '0;
        end
        else if (advance)
        begin
            win_reg      <= win_next;
            count_reg    <= count_next;
            reported_reg <= reported_next;
            stat_reg     <= stat_next;
        end
    end

    assign win   = win_reg;
    assign count = count_reg;
    assign stat  = stat_reg;

endmodule

>>> design/wbps_match.sv
// ----------------------------------------------------------------------------
// wbps_match
// Parallel compare of the byte window against the pattern, with offset and
// capture extraction.
// ----------------------------------------------------------------------------
module wbps_match import wbps_pkg::*;
(
    input  byte_win_t    win,
    input  count_t       count,
    input  cfg_derived_t derived,
    output match_res_t   res
);

    logic [MAX_PATTERN-1:0] tap_ok;
    count_t                 len_ext;
    count_t                 offset_full;
    logic [OUT_CAPS-1:0][BYTE_W-1:0] caps;

    // every exact tap must equal its pattern byte
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
            tap_ok[i] = ~derived.exact_win[i] | (win[i] == derived.expect_win[i]);
    end

    assign len_ext     = OFFSET_BITS'(derived.len);
    assign offset_full = count - len_ext;

    // captured bytes, first capture in the low byte
    always_comb
    begin
        caps = '0;
        for (int k = 0; k < CAP_SLOTS; k++)
        begin
            if (CAP_CNT_W'(k) < derived.cap_num)
                caps[k] = win[derived.cap_tap[k]];
        end
    end

    assign res.hit     = (count >= len_ext) & (&tap_ok);
    assign res.offset  = OFFSET_OUT_W'(offset_full);
    assign res.caps    = caps;
    assign res.cap_num = derived.cap_num;

endmodule

>>> design/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Scans a byte stream for the first match of a masked byte pattern.
// ----------------------------------------------------------------------------
// One byte is taken per clock unless a blocked result stalls the scan. Each
// accepted beat is shifted into a 16-byte window register; the window is
// then compared against all pattern positions in parallel and a result, if
// any, is loaded into the output register, so the sustained rate is one
// byte per cycle while the result channel keeps up. A found result carries
// the start offset and up to four captured bytes; after it the rest of the
// region is ignored. A region without a match gives a not-found result on
// its final byte. Pattern registers must be written while the scanner is
// idle, which the block does not enforce, and take effect once registered.
module wildcard_byte_pattern_scan import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    wbps_scan_if.sink              scan,
    wbps_result_if.source          result
);

    cfg_derived_t derived;
    byte_win_t    win;
    count_t       count;
    scan_stat_t   stat;
    match_res_t   res;

    logic emit;
    logic out_free;
    logic advance;
    logic accept;

    logic                    out_valid_reg;
    logic                    found_reg;
    logic [OFFSET_OUT_W-1:0] offset_reg;
    logic [CAPS_W-1:0]       caps_reg;
    logic [CAP_CNT_W-1:0]    cap_num_reg;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived)
    );

    wbps_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (scan.data_byte),
        .region_end (scan.region_end),
        .advance    (advance),
        .hit        (res.hit),
        .win        (win),
        .count      (count),
        .stat       (stat)
    );

    wbps_match u_match (
        .win     (win),
        .count   (count),
        .derived (derived),
        .res     (res)
    );

    // stage control: the window stage moves on unless its result is blocked
    assign emit       = stat.valid & stat.active & (res.hit | stat.last);
    assign out_free   = ~out_valid_reg | result.ready;
    assign advance    = ~stat.valid | ~emit | out_free;
    assign accept     = scan.valid & advance;
    assign scan.ready = advance;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit && advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat payload, zero for not found
    always_ff @(posedge clk)
    begin
        if (emit && advance)
        begin
            found_reg   <= res.hit;
            offset_reg  <= res.hit ? res.offset  : '0;
            caps_reg    <= res.hit ? res.caps    : '0;
            cap_num_reg <= res.hit ? res.cap_num : '0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = found_reg;
    assign result.match_offset   = offset_reg;
    assign result.captured_bytes = caps_reg;
    assign result.capture_count  = cap_num_reg;

endmodule
